// ===== sv/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg
// shared constants and types of the pinhole point projection block
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int CFG_W         = 64;
  localparam int NUM_CFG       = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int PROD_W        = 64;
  localparam int SUM_W         = 66;
  localparam int QUO_W         = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5
  } cfg_reg_t;

  // sign and special case info that travels beside the dividers
  typedef struct packed {
    logic neg_u;
    logic neg_v;
    logic zero;
  } side_t;

endpackage

// ===== sv/ppp_if.sv =====
// ----------------------------------------------------------------------------
// ppp_if
// valid/ready channels for world points and projected image points
// ----------------------------------------------------------------------------
interface ppp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;

  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface ppp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] image_u;
  logic signed [31:0] image_v;
  logic [1:0]         status;

  modport source (output valid, image_u, image_v, status, input ready);
  modport sink   (input valid, image_u, image_v, status, output ready);
endinterface

// ===== sv/ppp_div.sv =====
// ----------------------------------------------------------------------------
// ppp_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module ppp_div #(
  parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ppp_pkg::SUM_W-1:0]     num_mag,
  input  logic [ppp_pkg::SUM_W-1:0]     den_mag,
  output logic [ppp_pkg::QUO_W-1:0]     quo,
  output logic                          ovf
);

  localparam int QW = ppp_pkg::QUO_W;
  localparam int DW = ppp_pkg::SUM_W + QW;

  logic [DW-1:0]                 rem_r [0:QW];
  logic [ppp_pkg::SUM_W-1:0]     den_r [0:QW];
  logic [QW-1:0]                 q_r   [0:QW];
  logic                          ovf_r [0:QW];

  logic [DW-1:0] num_sh;
  logic [DW-1:0] den_sh;

  assign num_sh = DW'(num_mag) << FRAC_BITS;
  assign den_sh = DW'(den_mag) << QW;

  // quotient of 2^32 or more always saturates
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_sh;
      den_r[0] <= den_mag;
      q_r[0]   <= '0;
      ovf_r[0] <= (num_sh >= den_sh);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [DW-1:0] trial;
    logic          ge;
    assign trial = DW'(den_r[k]) << B;
    assign ge    = (rem_r[k] >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? (rem_r[k] - trial) : rem_r[k];
        den_r[k+1] <= den_r[k];
        q_r[k+1]   <= q_r[k] | (QW'(ge) << B);
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign quo = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

// ===== sv/pinhole_point_projection.sv =====
// ----------------------------------------------------------------------------
// pinhole_point_projection
// 3x4 matrix projection of a fixed point world point onto the image plane
// ----------------------------------------------------------------------------
// pipeline stages: multiply, sum, magnitude, 33 divider stages,
//   saturate/output register
// throughput: one point per cycle; the whole pipeline holds while a result
//   waits on the output
// reset: matrix returns to [I | 0], all stage valid bits cleared
module pinhole_point_projection #(
  parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ppp_in_if.sink                          in_ch,
  ppp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppp_pkg::CFG_W-1:0]       cfg_data
);

  localparam int SW  = ppp_pkg::SUM_W;
  localparam int PW  = ppp_pkg::PROD_W;
  localparam int CW  = ppp_pkg::COORD_W;
  localparam int QW  = ppp_pkg::QUO_W;
  localparam int DL  = QW + 1;
  localparam logic [ppp_pkg::CFG_W-1:0] ONE_LO = ppp_pkg::CFG_W'(1) << FRAC_BITS;
  localparam logic [ppp_pkg::CFG_W-1:0] ONE_HI = ppp_pkg::CFG_W'(1) << (CW + FRAC_BITS);

  logic [ppp_pkg::CFG_W-1:0] cfg_r [ppp_pkg::NUM_CFG];
  logic adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[ppp_pkg::REG_ROW0_COLS01] <= ONE_LO;
      cfg_r[ppp_pkg::REG_ROW0_COLS23] <= '0;
      cfg_r[ppp_pkg::REG_ROW1_COLS01] <= ONE_HI;
      cfg_r[ppp_pkg::REG_ROW1_COLS23] <= '0;
      cfg_r[ppp_pkg::REG_ROW2_COLS01] <= '0;
      cfg_r[ppp_pkg::REG_ROW2_COLS23] <= ONE_LO;
    end else if (cfg_we) begin
      case (cfg_index)
        ppp_pkg::REG_ROW0_COLS01, ppp_pkg::REG_ROW0_COLS23,
        ppp_pkg::REG_ROW1_COLS01, ppp_pkg::REG_ROW1_COLS23,
        ppp_pkg::REG_ROW2_COLS01, ppp_pkg::REG_ROW2_COLS23:
          cfg_r[cfg_index] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv         = !out_ch.valid || out_ch.ready;
  // no transfer is taken while in reset
  assign in_ch.ready = rst_n && adv;

  // stage 1: products
  logic signed [PW-1:0] prod_r [3][4];
  logic                 v1_r;

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [CW-1:0] m0, m1, m2, m3;
    logic signed [PW-1:0] p0, p1, p2, p3;
    assign m0 = signed'(cfg_r[2*r][CW-1:0]);
    assign m1 = signed'(cfg_r[2*r][2*CW-1:CW]);
    assign m2 = signed'(cfg_r[2*r+1][CW-1:0]);
    assign m3 = signed'(cfg_r[2*r+1][2*CW-1:CW]);
    assign p0 = m0 * in_ch.coord_x;
    assign p1 = m1 * in_ch.coord_y;
    assign p2 = m2 * in_ch.coord_z;
    assign p3 = PW'(m3) <<< FRAC_BITS;
    always_ff @(posedge clk) begin
      if (adv) begin
        prod_r[r][0] <= p0;
        prod_r[r][1] <= p1;
        prod_r[r][2] <= p2;
        prod_r[r][3] <= p3;
      end
    end
  end

  // stage 2: row sums
  logic signed [SW-1:0] sum_r [3];
  logic                 v2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        sum_r[r] <= SW'(prod_r[r][0]) + SW'(prod_r[r][1])
                  + SW'(prod_r[r][2]) + SW'(prod_r[r][3]);
      end
    end
  end

  // stage 3: magnitudes and signs
  logic [SW-1:0]   mag_r [3];
  ppp_pkg::side_t  side3_r;
  logic            v3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        mag_r[r] <= sum_r[r][SW-1] ? SW'(-sum_r[r]) : SW'(sum_r[r]);
      end
      side3_r.neg_u <= sum_r[0][SW-1] ^ sum_r[2][SW-1];
      side3_r.neg_v <= sum_r[1][SW-1] ^ sum_r[2][SW-1];
      side3_r.zero  <= (sum_r[2] == '0);
    end
  end

  // dividers
  logic [QW-1:0] q_u, q_v;
  logic          ovf_u, ovf_v;

  ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
    .clk(clk), .en(adv), .num_mag(mag_r[0]), .den_mag(mag_r[2]),
    .quo(q_u), .ovf(ovf_u)
  );

  ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
    .clk(clk), .en(adv), .num_mag(mag_r[1]), .den_mag(mag_r[2]),
    .quo(q_v), .ovf(ovf_v)
  );

  ppp_pkg::side_t side_r [DL];
  logic           vd_r   [DL];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side3_r;
      for (int k = 1; k < DL; k++) side_r[k] <= side_r[k-1];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int k = 0; k < DL; k++) vd_r[k] <= 1'b0;
    end else if (adv) begin
      v1_r    <= in_ch.valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      vd_r[0] <= v3_r;
      for (int k = 1; k < DL; k++) vd_r[k] <= vd_r[k-1];
    end
  end

  // final stage: sign, saturation, status
  function automatic logic [QW:0] fix_sign(input logic [QW-1:0] q, input logic ovf,
                                           input logic neg);
    logic          sat;
    logic [QW-1:0] val;
    sat = ovf || (neg ? (q > (QW'(1) << (QW-1))) : q[QW-1]);
    if (sat) val = neg ? (QW'(1) << (QW-1)) : ~(QW'(1) << (QW-1));
    else     val = neg ? QW'(-q) : q;
    return {sat, val};
  endfunction

  logic [QW:0]      fu, fv;
  logic [QW-1:0]    u_nxt, v_nxt;
  ppp_pkg::status_t st_nxt;
  ppp_pkg::side_t   sd;

  always_comb begin
    sd = side_r[DL-1];
    fu = fix_sign(q_u, ovf_u, sd.neg_u);
    fv = fix_sign(q_v, ovf_v, sd.neg_v);
    if (sd.zero) begin
      u_nxt  = '0;
      v_nxt  = '0;
      st_nxt = ppp_pkg::ST_DIV_ZERO;
    end else begin
      u_nxt  = fu[QW-1:0];
      v_nxt  = fv[QW-1:0];
      st_nxt = (fu[QW] || fv[QW]) ? ppp_pkg::ST_SAT : ppp_pkg::ST_OK;
    end
  end

  logic [QW-1:0] image_u_r, image_v_r;
  logic [1:0]    status_r;
  logic          out_valid_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      image_u_r <= u_nxt;
      image_v_r <= v_nxt;
      status_r  <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)   out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= vd_r[DL-1];
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.image_u = signed'(image_u_r);
  assign out_ch.image_v = signed'(image_v_r);
  assign out_ch.status  = status_r;

endmodule
